// ----- hw/rtl/arwh_pkg.sv -----
// ============================================================================
// Arrowhead vertex generator package
// Shared widths, register indexes and reset values of the arrowhead block.
// ============================================================================
`default_nettype none

package arwh_pkg;

  localparam int OUT_W = 14;
  localparam int OUT_MAX = 8191;
  localparam int OUT_MIN = -8192;
  localparam int CFG_W = 8;
  localparam int CFG_INDEX_W = 8;
  localparam int LEN_SHIFT = 15;

  localparam logic [CFG_INDEX_W-1:0] REG_HEAD_LENGTH = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEAD_WIDTH = 8'd1;

  localparam logic [CFG_W-1:0] HEAD_LENGTH_RESET = 8'd20;
  localparam logic [CFG_W-1:0] HEAD_WIDTH_RESET = 8'd15;

endpackage

`default_nettype wire

// ----- hw/rtl/arrowhead_vertex_generator_top.sv -----
// ============================================================================
// Arrowhead vertex generator
// Turns a segment into the two barb points of its arrowhead.
// ============================================================================
// One segment is taken in every clock cycle and busy never rises. Each result
// appears with a one-cycle done strobe after its start transfer has passed
// through the pipelined square root (one root bit per stage) and the two
// pipelined dividers (one quotient bit per stage). The receiver cannot hold
// results off.
`default_nettype none

module arrowhead_vertex_generator_top #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [COORD_BITS-1:0]               tail_x,
  input  wire logic [COORD_BITS-1:0]               tail_y,
  input  wire logic [COORD_BITS-1:0]               head_x,
  input  wire logic [COORD_BITS-1:0]               head_y,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [arwh_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [arwh_pkg::CFG_W-1:0]          cfg_data,
  output logic                                     done,
  output logic signed [arwh_pkg::OUT_W-1:0]        barb_one_x,
  output logic signed [arwh_pkg::OUT_W-1:0]        barb_one_y,
  output logic signed [arwh_pkg::OUT_W-1:0]        barb_two_x,
  output logic signed [arwh_pkg::OUT_W-1:0]        barb_two_y,
  output logic                                     degenerate
);

  localparam int DW = COORD_BITS + 1;
  localparam int SW = 2 * COORD_BITS + 1;
  localparam int NS = COORD_BITS + 16;
  localparam int VW = 2 * NS;
  localparam int ROOT_W = NS;
  localparam int RMW = ROOT_W + 2;
  localparam int QW = FRAC_BITS + 3;
  localparam int PW1 = DW + QW;
  localparam int XW = COORD_BITS + FRAC_BITS + 6;
  localparam int PW2 = XW + QW;
  localparam int TW = PW2 + 2;
  localparam int IW = TW - 2 * FRAC_BITS;
  localparam int DIV_PRE = FRAC_BITS + arwh_pkg::LEN_SHIFT + 1 - QW;
  localparam int VPAD = VW - SW - 2 * arwh_pkg::LEN_SHIFT;

  typedef struct packed {
    logic                    valid;
    logic [COORD_BITS-1:0]   hx;
    logic [COORD_BITS-1:0]   hy;
    logic signed [DW-1:0]    dx;
    logic signed [DW-1:0]    dy;
    logic [VW-1:0]           v;
    logic [ROOT_W-1:0]       root;
    logic [RMW-1:0]          rem;
  } sqrt_stage_t;

  typedef struct packed {
    logic                    valid;
    logic                    degen;
    logic [COORD_BITS-1:0]   hx;
    logic [COORD_BITS-1:0]   hy;
    logic                    neg_x;
    logic                    neg_y;
    logic [ROOT_W-1:0]       len;
    logic [ROOT_W-1:0]       rx;
    logic [ROOT_W-1:0]       ry;
    logic [QW-1:0]           qx;
    logic [QW-1:0]           qy;
  } div_stage_t;

  logic [arwh_pkg::CFG_W-1:0] head_length;
  logic [arwh_pkg::CFG_W-1:0] head_width;

  sqrt_stage_t sq [NS+1];
  sqrt_stage_t sq_next [NS+1];
  div_stage_t dv [QW+1];
  div_stage_t dv_next [QW+1];

  logic                    u_valid, u_degen;
  logic [COORD_BITS-1:0]   u_hx, u_hy;
  logic signed [QW-1:0]    u_cs, u_sn;

  logic                    m1_valid, m1_degen;
  logic signed [QW-1:0]    m1_cs, m1_sn;
  logic signed [PW1-1:0]   m1_hxc, m1_hys, m1_hxs, m1_hyc;

  logic                    m2_valid, m2_degen;
  logic signed [QW-1:0]    m2_cs, m2_sn;
  logic signed [XW-1:0]    m2_x, m2_y1, m2_y2;

  logic                    m3_valid, m3_degen;
  logic signed [PW2-1:0]   m3_xc, m3_xs, m3_y1s, m3_y1c, m3_y2s, m3_y2c;

  logic                    m4_valid, m4_degen;
  logic signed [TW-1:0]    m4_t [4];

  logic signed [TW-1:0]    fin_t [4];
  logic signed [IW-1:0]    fin_i [4];
  logic signed [arwh_pkg::OUT_W-1:0] fin_o [4];

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_length <= arwh_pkg::HEAD_LENGTH_RESET;
      head_width <= arwh_pkg::HEAD_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        arwh_pkg::REG_HEAD_LENGTH: head_length <= cfg_data;
        arwh_pkg::REG_HEAD_WIDTH:  head_width <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic signed [DW-1:0]   dx, dy;
    logic [COORD_BITS-1:0]  mx, my;
    logic [SW-1:0]          s;
    logic [RMW+1:0]         rem_t, trial;
    dx = $signed({1'b0, head_x}) - $signed({1'b0, tail_x});
    dy = $signed({1'b0, tail_y}) - $signed({1'b0, head_y});
    mx = dx[DW-1] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    my = dy[DW-1] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    s = SW'(mx * mx) + SW'(my * my);
    sq_next[0].valid = start && !busy && !rst;
    sq_next[0].hx = head_x;
    sq_next[0].hy = head_y;
    sq_next[0].dx = dx;
    sq_next[0].dy = dy;
    sq_next[0].v = {{VPAD{1'b0}}, s, {(2 * arwh_pkg::LEN_SHIFT){1'b0}}};
    sq_next[0].root = '0;
    sq_next[0].rem = '0;
    for (int k = 0; k < NS; k++) begin
      rem_t = {sq[k].rem, sq[k].v[VW-1 -: 2]};
      trial = {2'b00, sq[k].root, 2'b01};
      sq_next[k+1] = sq[k];
      sq_next[k+1].valid = sq[k].valid && !rst;
      sq_next[k+1].v = {sq[k].v[VW-3:0], 2'b00};
      if (rem_t >= trial) begin
        sq_next[k+1].rem = RMW'(rem_t - trial);
        sq_next[k+1].root = {sq[k].root[ROOT_W-2:0], 1'b1};
      end else begin
        sq_next[k+1].rem = RMW'(rem_t);
        sq_next[k+1].root = {sq[k].root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    logic [COORD_BITS-1:0]  mx, my;
    logic [ROOT_W:0]        tx, ty;
    mx = sq[NS].dx[DW-1] ? COORD_BITS'(-sq[NS].dx) : sq[NS].dx[COORD_BITS-1:0];
    my = sq[NS].dy[DW-1] ? COORD_BITS'(-sq[NS].dy) : sq[NS].dy[COORD_BITS-1:0];
    dv_next[0].valid = sq[NS].valid && !rst;
    dv_next[0].degen = (sq[NS].root == '0);
    dv_next[0].hx = sq[NS].hx;
    dv_next[0].hy = sq[NS].hy;
    dv_next[0].neg_x = sq[NS].dx[DW-1];
    dv_next[0].neg_y = sq[NS].dy[DW-1];
    dv_next[0].len = sq[NS].root;
    dv_next[0].rx = ROOT_W'(mx) << DIV_PRE;
    dv_next[0].ry = ROOT_W'(my) << DIV_PRE;
    dv_next[0].qx = '0;
    dv_next[0].qy = '0;
    for (int k = 0; k < QW; k++) begin
      tx = {dv[k].rx, 1'b0};
      ty = {dv[k].ry, 1'b0};
      dv_next[k+1] = dv[k];
      dv_next[k+1].valid = dv[k].valid && !rst;
      if (tx >= {1'b0, dv[k].len}) begin
        dv_next[k+1].rx = ROOT_W'(tx - {1'b0, dv[k].len});
        dv_next[k+1].qx = {dv[k].qx[QW-2:0], 1'b1};
      end else begin
        dv_next[k+1].rx = tx[ROOT_W-1:0];
        dv_next[k+1].qx = {dv[k].qx[QW-2:0], 1'b0};
      end
      if (ty >= {1'b0, dv[k].len}) begin
        dv_next[k+1].ry = ROOT_W'(ty - {1'b0, dv[k].len});
        dv_next[k+1].qy = {dv[k].qy[QW-2:0], 1'b1};
      end else begin
        dv_next[k+1].ry = ty[ROOT_W-1:0];
        dv_next[k+1].qy = {dv[k].qy[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= NS; k++) begin
      sq[k] <= sq_next[k];
    end
    for (int k = 0; k <= QW; k++) begin
      dv[k] <= dv_next[k];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      fin_t[i] = m4_t[i];
      if (fin_t[i] < 0) begin
        fin_t[i] = fin_t[i] + TW'((64'd1 << (2 * FRAC_BITS)) - 64'd1);
      end
      fin_i[i] = IW'(fin_t[i] >>> (2 * FRAC_BITS));
      if (fin_i[i] > arwh_pkg::OUT_MAX) begin
        fin_o[i] = arwh_pkg::OUT_W'(arwh_pkg::OUT_MAX);
      end else if (fin_i[i] < arwh_pkg::OUT_MIN) begin
        fin_o[i] = arwh_pkg::OUT_W'(arwh_pkg::OUT_MIN);
      end else begin
        fin_o[i] = fin_i[i][arwh_pkg::OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [QW-1:0] vx, vy;
    vx = QW'((dv[QW].qx + 1'b1) >> 1);
    vy = QW'((dv[QW].qy + 1'b1) >> 1);
    u_degen <= dv[QW].degen;
    u_hx <= dv[QW].hx;
    u_hy <= dv[QW].hy;
    u_cs <= dv[QW].neg_x ? -$signed(vx) : $signed(vx);
    u_sn <= dv[QW].neg_y ? -$signed(vy) : $signed(vy);

    m1_degen <= u_degen;
    m1_cs <= u_cs;
    m1_sn <= u_sn;
    m1_hxc <= PW1'($signed({1'b0, u_hx}) * u_cs);
    m1_hys <= PW1'($signed({1'b0, u_hy}) * u_sn);
    m1_hxs <= PW1'($signed({1'b0, u_hx}) * u_sn);
    m1_hyc <= PW1'($signed({1'b0, u_hy}) * u_cs);

    m2_degen <= m1_degen;
    m2_cs <= m1_cs;
    m2_sn <= m1_sn;
    m2_x <= XW'(m1_hxc) - XW'(m1_hys)
            - $signed({{(XW - arwh_pkg::CFG_W - FRAC_BITS){1'b0}}, head_length,
                       {FRAC_BITS{1'b0}}});
    m2_y1 <= XW'(m1_hxs) + XW'(m1_hyc)
             - $signed({{(XW - arwh_pkg::CFG_W - FRAC_BITS + 1){1'b0}},
                        head_width[arwh_pkg::CFG_W-1:1], {FRAC_BITS{1'b0}}});
    m2_y2 <= XW'(m1_hxs) + XW'(m1_hyc)
             + $signed({{(XW - arwh_pkg::CFG_W - FRAC_BITS + 1){1'b0}},
                        head_width[arwh_pkg::CFG_W-1:1], {FRAC_BITS{1'b0}}});

    m3_degen <= m2_degen;
    m3_xc <= PW2'(m2_x * m2_cs);
    m3_xs <= PW2'(m2_x * m2_sn);
    m3_y1s <= PW2'(m2_y1 * m2_sn);
    m3_y1c <= PW2'(m2_y1 * m2_cs);
    m3_y2s <= PW2'(m2_y2 * m2_sn);
    m3_y2c <= PW2'(m2_y2 * m2_cs);

    m4_degen <= m3_degen;
    m4_t[0] <= TW'(m3_xc) + TW'(m3_y1s) + TW'(64'd1 << (2 * FRAC_BITS - 1));
    m4_t[1] <= TW'(m3_y1c) - TW'(m3_xs) + TW'(64'd1 << (2 * FRAC_BITS - 1));
    m4_t[2] <= TW'(m3_xc) + TW'(m3_y2s) + TW'(64'd1 << (2 * FRAC_BITS - 1));
    m4_t[3] <= TW'(m3_y2c) - TW'(m3_xs) + TW'(64'd1 << (2 * FRAC_BITS - 1));

    degenerate <= m4_degen;
    barb_one_x <= m4_degen ? '0 : fin_o[0];
    barb_one_y <= m4_degen ? '0 : fin_o[1];
    barb_two_x <= m4_degen ? '0 : fin_o[2];
    barb_two_y <= m4_degen ? '0 : fin_o[3];

    if (rst) begin
      u_valid <= 1'b0;
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
      m4_valid <= 1'b0;
      done <= 1'b0;
    end else begin
      u_valid <= dv[QW].valid;
      m1_valid <= u_valid;
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
      m4_valid <= m3_valid;
      done <= m4_valid;
    end
  end

endmodule

`default_nettype wire
